// ===== design/mkr_pkg.sv =====
// Shared types and constants for the MQTT keep-alive frame receiver.
package mkr_pkg;

  localparam int LEN_W  = 28;
  localparam int IDLE_W = 26;

  // Parse phases
  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Result events
  localparam logic [1:0] EV_PACKET    = 2'd0;
  localparam logic [1:0] EV_PINGREQ   = 2'd1;
  localparam logic [1:0] EV_TIMEOUT   = 2'd2;
  localparam logic [1:0] EV_MALFORMED = 2'd3;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [3:0] TYPE_PINGREQ  = 4'd12;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  localparam logic [2:0] LEN_LAST_BYTE = 3'd3;

  localparam logic [IDLE_W-1:0] IDLE_MAX     = {IDLE_W{1'b1}};
  localparam logic [15:0]       KA_RESET     = 16'd15;
  localparam logic [9:0]        MS_PER_S     = 10'd1000;
  localparam logic [IDLE_W-1:0] LIMIT_RESET  = IDLE_W'(15 * 1000);

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       link_up;
  } item_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [3:0]       packet_type;
    logic [LEN_W-1:0] remaining_length;
    logic             send_ping_response;
  } result_t;

endpackage

// ===== design/mkr_if.sv =====
// Valid/ready channel interfaces for input items and result words.
interface mkr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       link_up;

  modport source(output valid, req_type, rx_byte, link_up, input ready);
  modport sink(input valid, req_type, rx_byte, link_up, output ready);
endinterface

interface mkr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [3:0]  packet_type;
  logic [27:0] remaining_length;
  logic        send_ping_response;

  modport source(output valid, event_res, packet_type, remaining_length,
                 send_ping_response, input ready);
  modport sink(input valid, event_res, packet_type, remaining_length,
               send_ping_response, output ready);
endinterface

// ===== design/mkr_engine.sv =====
// Framing state, keep-alive counters and the per-word step logic.
module mkr_engine import mkr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        res_valid,
  output result_t     res
);

  logic [1:0]        phase_r, phase_nxt;
  logic [3:0]        type_r, type_nxt;
  logic [LEN_W-1:0]  accum_r, accum_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  body_r, body_nxt;
  logic [IDLE_W-1:0] idle_in_r, idle_in_nxt;
  logic [IDLE_W-1:0] idle_out_r, idle_out_nxt;
  logic              ping_r, ping_nxt;
  logic [IDLE_W-1:0] limit_r, limit_nxt;

  logic [LEN_W-1:0]  shifted;
  logic [LEN_W-1:0]  accum_new;
  logic [LEN_W-1:0]  body_inc;
  logic [IDLE_W-1:0] in_inc, out_inc;
  logic              is_pingreq;

  // Limit is kept in milliseconds so the tick path only compares.
  assign limit_nxt = cfg_we ? IDLE_W'(cfg_wdata) * IDLE_W'(MS_PER_S) : limit_r;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: shifted = {21'b0, item.rx_byte[6:0]};
      2'd1: shifted = {14'b0, item.rx_byte[6:0], 7'b0};
      2'd2: shifted = {7'b0, item.rx_byte[6:0], 14'b0};
      2'd3: shifted = {item.rx_byte[6:0], 21'b0};
      default: shifted = '0;
    endcase
  end

  assign accum_new  = accum_r | shifted;
  assign body_inc   = body_r + LEN_W'(1);
  assign in_inc     = (idle_in_r < IDLE_MAX) ? idle_in_r + IDLE_W'(1) : idle_in_r;
  assign out_inc    = (idle_out_r < IDLE_MAX) ? idle_out_r + IDLE_W'(1) : idle_out_r;
  assign is_pingreq = (type_r == TYPE_PINGREQ);

  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    accum_nxt    = accum_r;
    cnt_nxt      = cnt_r;
    body_nxt     = body_r;
    idle_in_nxt  = idle_in_r;
    idle_out_nxt = idle_out_r;
    ping_nxt     = ping_r;
    res_valid    = 1'b0;
    res          = '0;

    if (fire) begin
      if (!item.link_up) begin
        phase_nxt    = PH_TYPE;
        type_nxt     = '0;
        accum_nxt    = '0;
        cnt_nxt      = '0;
        body_nxt     = '0;
        idle_in_nxt  = '0;
        idle_out_nxt = '0;
        ping_nxt     = 1'b0;
      end else if (item.req_type == REQ_TICK) begin
        idle_in_nxt  = in_inc;
        idle_out_nxt = out_inc;
        if (in_inc > limit_r || out_inc > limit_r) begin
          res_valid    = 1'b1;
          idle_in_nxt  = '0;
          idle_out_nxt = '0;
          if (ping_r) begin
            // connection considered closed: drop all framing state
            res.event_res = EV_TIMEOUT;
            phase_nxt     = PH_TYPE;
            type_nxt      = '0;
            accum_nxt     = '0;
            cnt_nxt       = '0;
            body_nxt      = '0;
            ping_nxt      = 1'b0;
          end else begin
            res.event_res = EV_PINGREQ;
            ping_nxt      = 1'b1;
          end
        end
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            if (cnt_r > LEN_LAST_BYTE ||
                (cnt_r == LEN_LAST_BYTE && item.rx_byte[7])) begin
              res_valid       = 1'b1;
              res.event_res   = EV_MALFORMED;
              res.packet_type = type_r;
              phase_nxt       = PH_TYPE;
              accum_nxt       = '0;
              cnt_nxt         = '0;
            end else begin
              accum_nxt = accum_new;
              cnt_nxt   = cnt_r + 3'd1;
              if (!item.rx_byte[7]) begin
                if (accum_new == '0) begin
                  // zero length: complete on the last length byte
                  res_valid              = 1'b1;
                  res.event_res          = EV_PACKET;
                  res.packet_type        = type_r;
                  res.remaining_length   = accum_new;
                  res.send_ping_response = is_pingreq;
                  idle_in_nxt            = '0;
                  if (is_pingreq) idle_out_nxt = '0;
                  if (type_r == TYPE_PINGRESP) ping_nxt = 1'b0;
                  phase_nxt = PH_TYPE;
                  accum_nxt = '0;
                  cnt_nxt   = '0;
                  body_nxt  = '0;
                end else begin
                  phase_nxt = PH_BODY;
                  body_nxt  = '0;
                end
              end
            end
          end
          PH_BODY: begin
            body_nxt = body_inc;
            if (body_inc >= accum_r) begin
              res_valid              = 1'b1;
              res.event_res          = EV_PACKET;
              res.packet_type        = type_r;
              res.remaining_length   = accum_r;
              res.send_ping_response = is_pingreq;
              idle_in_nxt            = '0;
              if (is_pingreq) idle_out_nxt = '0;
              if (type_r == TYPE_PINGRESP) ping_nxt = 1'b0;
              phase_nxt = PH_TYPE;
              accum_nxt = '0;
              cnt_nxt   = '0;
              body_nxt  = '0;
            end
          end
          default: begin
            // type byte; the unused phase code lands here too
            type_nxt  = item.rx_byte[7:4];
            phase_nxt = PH_LEN;
            accum_nxt = '0;
            cnt_nxt   = '0;
            body_nxt  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      type_r     <= '0;
      accum_r    <= '0;
      cnt_r      <= '0;
      body_r     <= '0;
      idle_in_r  <= '0;
      idle_out_r <= '0;
      ping_r     <= 1'b0;
      limit_r    <= LIMIT_RESET;
    end else begin
      phase_r    <= phase_nxt;
      type_r     <= type_nxt;
      accum_r    <= accum_nxt;
      cnt_r      <= cnt_nxt;
      body_r     <= body_nxt;
      idle_in_r  <= idle_in_nxt;
      idle_out_r <= idle_out_nxt;
      ping_r     <= ping_nxt;
      limit_r    <= limit_nxt;
    end
  end

endmodule

// ===== design/mkr_out_reg.sv =====
// Result register that drives the output channel.
module mkr_out_reg import mkr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      res_valid,
  input  result_t   res,
  mkr_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.event_res          = data_r.event_res;
  assign out_ch.packet_type        = data_r.packet_type;
  assign out_ch.remaining_length   = data_r.remaining_length;
  assign out_ch.send_ping_response = data_r.send_ping_response;

endmodule

// ===== design/mqtt_keepalive_frame_receiver.sv =====
// Top level of the MQTT fixed-header framer and keep-alive monitor.
//
// in_ch carries one word per received byte or per millisecond tick, with
// link_up qualifying it; a word with link_up low clears all framing and
// keep-alive state and yields nothing. out_ch carries at most one result
// word per input word: packet received, send PINGREQ, keep-alive timeout
// or malformed length. cfg_we/cfg_wdata set the keep-alive interval in
// seconds (reset 15); write it only while no words are in flight.
// A word is taken into an input register, stepped through the framing
// logic once the output register is free or draining, and its result
// lands in the output register. in_ch takes one word per cycle while
// out_ch is not stalled. When out_ch stalls with a result held, the input
// register still takes one more word, and in_ch.ready drops only
// while both registers are full. Synchronous reset empties both
// registers and returns all state and the interval to reset values.
module mqtt_keepalive_frame_receiver import mkr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mkr_in_if.sink      in_ch,
  mkr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    fire;
  logic    in_take;
  logic    res_valid;
  result_t res;

  // advance the held word when the result register is free or draining
  assign fire        = s1_valid_r && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.req_type <= in_ch.req_type;
      s1_item_r.rx_byte  <= in_ch.rx_byte;
      s1_item_r.link_up  <= in_ch.link_up;
    end
  end

  mkr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  mkr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ch    (out_ch)
  );

  a_link_down_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_item_r.link_up |=> !out_ch.valid)
    else $error("link-down word produced a result");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_ch.valid && !out_ch.ready)
    else $error("input stalled without both registers full");

  a_timeout_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res == EV_TIMEOUT || out_ch.event_res == EV_PINGREQ)
    |-> out_ch.packet_type == 4'd0 && out_ch.remaining_length == '0 &&
        !out_ch.send_ping_response)
    else $error("keep-alive result carries packet fields");

endmodule

// ===== verif/mkr_event_checker.sv =====
`timescale 1ns / 1ps
// Checker for the MQTT keep-alive frame receiver: tracks framing state and compares result words.
module mkr_event_checker import mkr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mkr_in_if           in_ch,
  mkr_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [15:0]       ka_s;
  logic [1:0]        phase;
  logic [3:0]        cur_type;
  logic [LEN_W-1:0]  len_acc;
  logic [2:0]        len_cnt;
  logic [LEN_W-1:0]  body_cnt;
  logic [IDLE_W-1:0] idle_in;
  logic [IDLE_W-1:0] idle_out;
  logic              ping_out;

  result_t expected_events[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void clear_link_state();
    phase    = PH_TYPE;
    cur_type = '0;
    len_acc  = '0;
    len_cnt  = '0;
    body_cnt = '0;
    idle_in  = '0;
    idle_out = '0;
    ping_out = 1'b0;
  endfunction

  function automatic bit flag_overlong(output result_t r);
    r = '0;
    r.event_res   = EV_MALFORMED;
    r.packet_type = cur_type;
    phase   = PH_TYPE;
    len_acc = '0;
    len_cnt = '0;
    return 1'b1;
  endfunction

  function automatic bit finish_packet(output result_t r);
    r = '0;
    r.event_res          = EV_PACKET;
    r.packet_type        = cur_type;
    r.remaining_length   = len_acc;
    r.send_ping_response = (cur_type == TYPE_PINGREQ);
    idle_in = '0;
    // answering a PINGREQ counts as transmit activity
    if (cur_type == TYPE_PINGREQ) idle_out = '0;
    if (cur_type == TYPE_PINGRESP) ping_out = 1'b0;
    phase    = PH_TYPE;
    len_acc  = '0;
    len_cnt  = '0;
    body_cnt = '0;
    return 1'b1;
  endfunction

  // Advance the framer and keep-alive state by one word; return 1 when it yields a result.
  function automatic bit frame_keepalive_step(input item_t w, output result_t r);
    logic [2:0]  n;
    logic [31:0] limit;
    r = '0;
    if (!w.link_up) begin
      clear_link_state();
      return 1'b0;
    end
    if (w.req_type == REQ_TICK) begin
      limit = 32'(ka_s) * 32'(MS_PER_S);
      if (idle_in != IDLE_MAX) idle_in = idle_in + 1'b1;
      if (idle_out != IDLE_MAX) idle_out = idle_out + 1'b1;
      if (32'(idle_in) > limit || 32'(idle_out) > limit) begin
        if (ping_out) begin
          clear_link_state();
          r.event_res = EV_TIMEOUT;
        end else begin
          idle_in     = '0;
          idle_out    = '0;
          ping_out    = 1'b1;
          r.event_res = EV_PINGREQ;
        end
        return 1'b1;
      end
      return 1'b0;
    end
    case (phase)
      PH_LEN: begin
        n = len_cnt;
        if (n > LEN_LAST_BYTE) return flag_overlong(r);
        len_acc = len_acc | (LEN_W'(w.rx_byte[6:0]) << (7 * n));
        len_cnt = n + 3'd1;
        if (w.rx_byte[7]) begin
          if (n == LEN_LAST_BYTE) return flag_overlong(r);
          return 1'b0;
        end
        if (len_acc == '0) return finish_packet(r);
        phase    = PH_BODY;
        body_cnt = '0;
        return 1'b0;
      end
      PH_BODY: begin
        body_cnt = body_cnt + 1'b1;
        if (body_cnt >= len_acc) return finish_packet(r);
        return 1'b0;
      end
      default: begin
        cur_type = w.rx_byte[7:4];
        phase    = PH_LEN;
        len_acc  = '0;
        len_cnt  = '0;
        body_cnt = '0;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    item_t   w;
    result_t want;
    result_t pred;
    if (!rst_n) begin
      ka_s = KA_RESET;
      clear_link_state();
      expected_events.delete();
    end else begin
      if (cfg_we) ka_s = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result word: event_res %0d packet_type %0d",
                 out_ch.event_res, out_ch.packet_type);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_ch.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_ch.event_res);
            fail_count++;
          end
          if (out_ch.packet_type !== want.packet_type) begin
            $error("packet_type: expected %0d, got %0d", want.packet_type,
                   out_ch.packet_type);
            fail_count++;
          end
          if (out_ch.remaining_length !== want.remaining_length) begin
            $error("remaining_length: expected %0d, got %0d", want.remaining_length,
                   out_ch.remaining_length);
            fail_count++;
          end
          if (out_ch.send_ping_response !== want.send_ping_response) begin
            $error("send_ping_response: expected %0d, got %0d", want.send_ping_response,
                   out_ch.send_ping_response);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w.req_type = in_ch.req_type;
        w.rx_byte  = in_ch.rx_byte;
        w.link_up  = in_ch.link_up;
        if (frame_keepalive_step(w, pred)) expected_events.push_back(pred);
      end
    end
    pending = expected_events.size();
  end

endmodule

// ===== verif/tb_mqtt_keepalive_frame_receiver.sv =====
`timescale 1ns / 1ps
// Testbench top for the MQTT keep-alive frame receiver: stimulus, stalls and verdict.
module tb_mqtt_keepalive_frame_receiver import mkr_pkg::*;;

  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  bit no_gaps     = 1'b0;
  bit rx_hold_req = 1'b0;

  mkr_in_if  in_ch();
  mkr_out_if out_ch();

  mqtt_keepalive_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mkr_event_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word and hold it until it is taken.
  task automatic send_word(input logic req, input logic [7:0] b, input logic up);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.rx_byte  <= b;
    in_ch.link_up  <= up;
    do @(posedge clk); while (!in_ch.ready);
    if (up) items_sent++;
  endtask

  // Send a byte, now and then with a tick slipped in ahead of it.
  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) send_word(REQ_TICK, 8'($urandom), 1'b1);
    send_word(REQ_BYTE, b, 1'b1);
  endtask

  // Drop valid and wait until every expected result word is out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ka, input int n_items, input bit fast,
                           input int lead_ticks, input bit squeeze);
    int         stop_at;
    int         len;
    int         nbytes;
    int         r;
    logic [3:0] ptype;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ka;
    @(posedge clk);
    cfg_we <= 1'b0;
    no_gaps     = fast;
    rx_hold_req = squeeze;
    repeat (lead_ticks) send_word(REQ_TICK, 8'($urandom), 1'b1);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed packet; favor PINGREQ and PINGRESP
        r = $urandom_range(0, 9);
        ptype = (r < 3) ? TYPE_PINGREQ : (r < 5) ? TYPE_PINGRESP : 4'($urandom);
        r = $urandom_range(0, 9);
        len = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 20) : $urandom_range(21, 150);
        nbytes = (len < 128) ? 1 : 2;
        // pad the length field with zero groups now and then
        if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(nbytes, 4);
        put_byte({ptype, 4'($urandom)});
        for (int i = 0; i < nbytes; i++) put_byte({i < nbytes - 1, 7'(len >> (7 * i))});
        repeat (len) put_byte(8'($urandom));
      end else if (r < 78) begin
        // overlong length field
        put_byte(8'($urandom));
        repeat (4) put_byte({1'b1, 7'($urandom)});
      end else if (r < 86) begin
        put_byte(8'($urandom));
      end else if (r < 94) begin
        send_word(REQ_TICK, 8'($urandom), 1'b1);
      end else begin
        send_word(1'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        gap = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.rx_byte  = 8'h00;
    in_ch.link_up  = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 16'h0000;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero-length PINGREQ, then a zero-length PINGRESP
    send_word(REQ_BYTE, 8'hC0, 1'b1);
    send_word(REQ_BYTE, 8'h00, 1'b1);
    send_word(REQ_BYTE, 8'hD0, 1'b1);
    send_word(REQ_BYTE, 8'h00, 1'b1);
    // two body bytes at both extremes
    send_word(REQ_BYTE, 8'h3F, 1'b1);
    send_word(REQ_BYTE, 8'h02, 1'b1);
    send_word(REQ_BYTE, 8'hFF, 1'b1);
    send_word(REQ_BYTE, 8'h00, 1'b1);
    // fourth length byte still continues: malformed
    send_word(REQ_BYTE, 8'h5A, 1'b1);
    repeat (4) send_word(REQ_BYTE, 8'hFF, 1'b1);
    // padded zero length completes on its last length byte
    send_word(REQ_BYTE, 8'h20, 1'b1);
    send_word(REQ_BYTE, 8'h80, 1'b1);
    send_word(REQ_BYTE, 8'h00, 1'b1);
    send_word(REQ_TICK, 8'hFF, 1'b1);
    // link drop in the middle of a packet
    send_word(REQ_BYTE, 8'h10, 1'b1);
    send_word(REQ_BYTE, 8'h05, 1'b1);
    send_word(REQ_BYTE, 8'h01, 1'b1);
    send_word(REQ_TICK, 8'hFF, 1'b0);
    send_word(REQ_BYTE, 8'h00, 1'b0);

    run_phase(16'd0, 40, 1'b0, 0, 1'b0);
    // enough ticks to cross a one-second limit
    run_phase(16'd1, 30, 1'b1, 1003, 1'b0);
    run_phase(16'hFFFF, 30, 1'b0, 0, 1'b0);
    run_phase(16'd3, 60, 1'b1, 0, 1'b1);
    run_phase(16'd2, 30, 1'b0, 0, 1'b0);
    run_phase(16'd0, 30, 1'b1, 0, 1'b0);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
